// ===== design/histogram_equalizer_8bit_assert.svh =====
// Assertion macros used by the checker of the histogram equalizer.
`ifndef HISTOGRAM_EQUALIZER_8BIT_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_8BIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HEQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hequ_pkg.sv =====
// ============================================================================
// hequ_pkg
// Types and constants shared by the histogram equalizer modules.
// ============================================================================
package hequ_pkg;

    localparam int GRAY_LEVELS = 256;
    localparam int PIX_W       = 8;
    localparam int CNT_W       = 21;
    localparam int MAX_PIXELS  = 1048576;
    // 510 * count + total stays below 2^(CNT_W + 9).
    localparam int NUM_W       = CNT_W + 9;
    localparam int DEN_W       = CNT_W + 1;
    localparam int QUO_W       = 8;
    localparam int STEP_W      = 3;
    localparam int STAT_W      = 2;
    localparam int ACT_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_COUNT = 2'd1,
        ACT_REMAP = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_LIMIT = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_WR,
        S_BLD_RD,
        S_BLD_ACC,
        S_BLD_NUM,
        S_BLD_DIV,
        S_MAP_RD,
        S_MAP_DATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [PIX_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
        logic [PIX_W-1:0] rd_addr;
    } t_bin_cmd;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_res;

endpackage

// ===== design/hequ_bins.sv =====
// ============================================================================
// hequ_bins
// Histogram bin memory with one valid bit per bin, so all bins clear at once.
// ============================================================================
module hequ_bins
    import hequ_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bin_cmd         i_cmd,
    output logic [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0]       r_mem [GRAY_LEVELS];
    logic [GRAY_LEVELS-1:0] r_vld;
    logic [CNT_W-1:0]       r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_cmd.rd_addr];
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.wr_en) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    // A bin never written since the last clear reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== design/hequ_div.sv =====
// ============================================================================
// hequ_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module hequ_div
    import hequ_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_q;
    logic [NUM_W:0]    w_diff;
    logic              w_take;
    logic [NUM_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_q;

    assign w_diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_take = !w_diff[NUM_W];
    assign n_rem  = w_take ? w_diff[NUM_W-1:0] : r_rem;
    assign n_q    = {r_q[QUO_W-2:0], w_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The divisor starts aligned to the top quotient bit and moves right.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {{(NUM_W-DEN_W-QUO_W+1){1'b0}}, i_den, {(QUO_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= n_q;
        end
    end

    assign o_res.done = r_busy && (r_cnt == STEP_W'(QUO_W - 1));
    assign o_res.quo  = n_q;

endmodule

// ===== design/histogram_equalizer_8bit.sv =====
// ============================================================================
// histogram_equalizer_8bit
// Two-pass 8-bit gray level histogram equalizer.
// ============================================================================
// Input words carry an action in i_s_tuser (clear, count, remap) and a gray
// level in i_s_tdata. Every accepted word gives exactly one output word:
// the mapped gray level in o_m_tdata and a status in o_m_tuser.
// Clear, the unused action, a refused count and an empty remap go straight to
// the done state, which loads the output register; a count first passes the
// bin write state, a remap with a built table the map data state. The input
// is ready only in idle, so no new word is taken while one is in work.
// The first remap after any count that is not refused builds the 256-entry
// lookup table: each entry reads its bin, adds it to the running sum, forms
// the numerator and runs the single restoring divider for its quotient.
// Reset clears the histogram at once through per-bin valid bits; the table
// is rebuilt before any read, so it needs no clearing.
// A finished word waits in the output register; a new word is accepted
// meanwhile, and the block holds its next result until the receiver takes
// the waiting one.
// ============================================================================
module histogram_equalizer_8bit
    import hequ_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [PIX_W-1:0]  i_s_tdata,   // [7:0] pixel_value
    input  logic [ACT_W-1:0]  i_s_tuser,   // [1:0] action
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [PIX_W-1:0]  o_m_tdata,   // [7:0] mapped_pixel
    output logic [STAT_W-1:0] o_m_tuser    // [1:0] status
);

    t_state           r_state;
    t_state           n_state;
    t_action          w_act;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_run;
    logic [CNT_W-1:0] r_total;
    logic             r_tbl_rdy;
    logic [PIX_W-1:0] r_res_pix;
    t_status          r_res_st;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pix;
    t_status          r_out_st;
    logic [PIX_W-1:0] r_map [GRAY_LEVELS];
    logic [PIX_W-1:0] r_map_q;

    logic             w_accept;
    logic             w_at_limit;
    logic             w_empty;
    logic             w_out_load;
    logic             w_map_wr;
    logic [PIX_W-1:0] w_map_addr;
    logic             w_div_start;
    logic [NUM_W-1:0] w_num;
    t_bin_cmd         w_bin_cmd;
    logic [CNT_W-1:0] w_bin_rd;
    t_div_res         w_div;

    assign w_act      = t_action'(i_s_tuser);
    assign w_at_limit = (r_total >= CNT_W'(MAX_PIXELS));
    assign w_empty    = (r_total == '0);

    hequ_bins u_bins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_bin_cmd),
        .o_rd_data (w_bin_rd)
    );

    hequ_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   ({r_total, 1'b0}),
        .o_res   (w_div)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (w_act)
                        ACT_COUNT: n_state = w_at_limit ? S_DONE : S_CNT_WR;
                        ACT_REMAP: begin
                            priority if (w_empty) n_state = S_DONE;
                            else if (r_tbl_rdy)   n_state = S_MAP_DATA;
                            else                  n_state = S_BLD_RD;
                        end
                        ACT_CLEAR, ACT_NONE: n_state = S_DONE;
                    endcase
                end
            end
            S_CNT_WR:  n_state = S_DONE;
            S_BLD_RD:  n_state = S_BLD_ACC;
            S_BLD_ACC: n_state = S_BLD_NUM;
            S_BLD_NUM: n_state = S_BLD_DIV;
            S_BLD_DIV: begin
                if (w_div.done) begin
                    n_state = (r_idx == PIX_W'(GRAY_LEVELS - 1)) ? S_MAP_RD : S_BLD_RD;
                end
            end
            S_MAP_RD:   n_state = S_MAP_DATA;
            S_MAP_DATA: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_s_tready        = (r_state == S_IDLE);
        w_accept          = (r_state == S_IDLE) && i_s_tvalid;
        w_bin_cmd.clear   = w_accept && (w_act == ACT_CLEAR);
        w_bin_cmd.rd_addr = (r_state == S_IDLE) ? i_s_tdata : r_idx;
        w_bin_cmd.wr_en   = (r_state == S_CNT_WR);
        w_bin_cmd.wr_addr = r_pix;
        w_bin_cmd.wr_data = w_bin_rd + CNT_W'(1);
        w_div_start       = (r_state == S_BLD_NUM);
        w_map_wr          = (r_state == S_BLD_DIV) && w_div.done;
        w_map_addr        = (r_state == S_IDLE) ? i_s_tdata : r_pix;
        w_out_load        = (r_state == S_DONE) && (!r_out_vld || i_m_tready);
    end

    // Numerator 510 * running + total, rounding the scaled cumulative count.
    assign w_num = {r_run, 9'b0} - NUM_W'({r_run, 1'b0}) + NUM_W'(r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_tbl_rdy <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (w_act == ACT_CLEAR)) begin
                r_total   <= '0;
                r_tbl_rdy <= 1'b0;
            end
            if (r_state == S_CNT_WR) begin
                r_total   <= r_total + CNT_W'(1);
                r_tbl_rdy <= 1'b0;
            end
            if (w_map_wr && (r_idx == PIX_W'(GRAY_LEVELS - 1))) begin
                r_tbl_rdy <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix     <= i_s_tdata;
            r_idx     <= '0;
            r_run     <= '0;
            r_res_pix <= '0;
            r_res_st  <= ST_OK;
            if ((w_act == ACT_COUNT) && w_at_limit) begin
                r_res_st <= ST_LIMIT;
            end
            if ((w_act == ACT_REMAP) && w_empty) begin
                r_res_st <= ST_EMPTY;
            end
        end
        if (r_state == S_BLD_ACC) begin
            r_run <= r_run + w_bin_rd;
        end
        if (w_map_wr) begin
            r_idx <= r_idx + PIX_W'(1);
        end
        if (r_state == S_MAP_DATA) begin
            r_res_pix <= r_map_q;
        end
        if (w_out_load) begin
            r_out_pix <= r_res_pix;
            r_out_st  <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_wr) begin
            r_map[r_idx] <= w_div.quo;
        end
        r_map_q <= r_map[w_map_addr];
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tuser  = r_out_st;

endmodule

// ===== design/hequ_checker.sv =====
// ============================================================================
// hequ_checker
// Port-level checks of the histogram equalizer, bound to the top level.
// ============================================================================
`include "histogram_equalizer_8bit_assert.svh"

module hequ_checker
    import hequ_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [PIX_W-1:0]  i_s_tdata,
    input logic [ACT_W-1:0]  i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [PIX_W-1:0]  o_m_tdata,
    input logic [STAT_W-1:0] o_m_tuser
);

    // Any failing status carries a zero gray level.
    `HEQ_ASSERT_NOW(a_err_zero, o_m_tvalid && (o_m_tuser != ST_OK), o_m_tdata == '0, "error word with nonzero level")

    // The block works on one word at a time.
    `HEQ_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready, "input ready right after acceptance")

    // A stalled output word holds.
    `HEQ_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled output word changed")

endmodule

bind histogram_equalizer_8bit hequ_checker u_hequ_checker (.*);

// ===== tb/tb_histogram_equalizer_8bit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_histogram_equalizer_8bit
// Self-checking regression for the two-pass 8-bit histogram equalizer.
// ============================================================================
// A stimulus process queues input words. A clocked driver sends them in
// bursts with random gaps, and the receiver stalls on a pattern that keeps
// changing. Every accepted word is applied to a behavioral copy of the histogram
// and the lookup table. The monitor compares each output word, field by
// field, with the oldest prediction. The directed words come first, then
// random clear/count/remap sequences mixed with noise. A few closing words
// follow once the block has drained completely.
// ============================================================================
module tb_histogram_equalizer_8bit;
    import hequ_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 2;
    localparam int CYCLE_LIMIT   = 30_000_000;
    localparam int RANDOM_WORDS  = 1500;
    localparam int SETTLE_CYCLES = 20;

    // Receiver stall patterns.
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_COMB   = 2;
    localparam int RX_BURSTY = 3;

    typedef struct {
        t_action          act;
        logic [PIX_W-1:0] pix;
        bit               drain_first;
    } t_pixel_word;

    typedef struct {
        logic [PIX_W-1:0] mapped;
        t_status          status;
    } t_eq_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [PIX_W-1:0]  i_s_tdata;   // [7:0] pixel_value
    logic [ACT_W-1:0]  i_s_tuser;   // [1:0] action
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [PIX_W-1:0]  o_m_tdata;   // [7:0] mapped_pixel
    logic [STAT_W-1:0] o_m_tuser;   // [1:0] status

    histogram_equalizer_8bit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Behavioral histogram and lookup table.
    logic [CNT_W-1:0] hist_bins [GRAY_LEVELS];
    logic [CNT_W-1:0] hist_total;
    logic [PIX_W-1:0] gray_lut  [GRAY_LEVELS];
    bit               lut_valid;

    t_pixel_word pixel_words[$];
    t_eq_result  results_due[$];
    t_pixel_word next_word;
    t_eq_result  due;

    bit              word_taken;
    int unsigned     burst_left;
    int unsigned     gap_left;
    int unsigned     rx_mode;
    int unsigned     rx_left;
    int unsigned     rx_stall;
    int unsigned     words_sent;
    int unsigned     words_taken;
    int unsigned     err_count;
    int unsigned     n_counts;
    int unsigned     n_refused;
    int unsigned     n_remaps;
    int unsigned     n_empty;
    int unsigned     n_builds;
    longint unsigned cycle_count;

    function automatic void rebuild_gray_lut();
        longint unsigned running;
        longint unsigned denom;
        longint unsigned level;
        running = 0;
        denom   = 2 * longint'(hist_total);
        for (int g = 0; g < GRAY_LEVELS; g++) begin
            running += hist_bins[g];
            // Rounds 255 * running / total to the nearest integer.
            level = (510 * running + hist_total) / denom;
            if (level > 255)
                level = 255;
            gray_lut[g] = level[PIX_W-1:0];
        end
        lut_valid = 1'b1;
        n_builds++;
    endfunction

    function automatic t_eq_result equalize_word(t_action act, logic [PIX_W-1:0] pix);
        t_eq_result res;
        res.mapped = '0;
        res.status = ST_OK;
        case (act)
            ACT_CLEAR: begin
                for (int g = 0; g < GRAY_LEVELS; g++)
                    hist_bins[g] = '0;
                hist_total = '0;
                lut_valid  = 1'b0;
            end
            ACT_COUNT: begin
                n_counts++;
                if (hist_total >= MAX_PIXELS) begin
                    res.status = ST_LIMIT;
                    n_refused++;
                end else begin
                    hist_bins[pix] = hist_bins[pix] + 1'b1;
                    hist_total     = hist_total + 1'b1;
                    lut_valid      = 1'b0;
                end
            end
            ACT_REMAP: begin
                n_remaps++;
                if (hist_total == 0) begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    if (!lut_valid)
                        rebuild_gray_lut();
                    res.mapped = gray_lut[pix];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_word(t_action act, logic [PIX_W-1:0] pix, bit drain_first);
        t_pixel_word w;
        w.act         = act;
        w.pix         = pix;
        w.drain_first = drain_first;
        pixel_words.push_back(w);
        words_sent++;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
            $display("histogram_equalizer_8bit regression: fail");
            $finish;
        end
    end

    // A word is taken at the rising edge; its prediction is made right here.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            results_due.push_back(equalize_word(t_action'(i_s_tuser), i_s_tdata));
            words_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || word_taken)) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pixel_words.size() == 0 ||
                         (pixel_words[0].drain_first && results_due.size() != 0)) begin
                i_s_tvalid <= 1'b0;
            end else begin
                next_word  = pixel_words.pop_front();
                i_s_tdata  <= next_word.pix;
                i_s_tuser  <= next_word.act;
                i_s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 32);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_OPEN, RX_BURSTY);
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  i_m_tready <= 1'b1;
            RX_COIN:  i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_COMB:  i_m_tready <= (rx_left % 5 != 0);
            default: begin
                if (rx_stall != 0) begin
                    rx_stall   <= rx_stall - 1;
                    i_m_tready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall   <= $urandom_range(3, 15);
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected output word: mapped_pixel %0d, status %0d",
                       o_m_tdata, o_m_tuser);
                err_count++;
            end else begin
                due = results_due.pop_front();
                if (o_m_tdata !== due.mapped) begin
                    $error("mapped_pixel mismatch: expected %0d, actual %0d",
                           due.mapped, o_m_tdata);
                    err_count++;
                end
                if (o_m_tuser !== due.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           due.status, o_m_tuser);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        int          k;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = ACT_NONE;
        i_m_tready = 1'b0;
        for (k = 0; k < GRAY_LEVELS; k++)
            hist_bins[k] = '0;
        hist_total = '0;
        lut_valid  = 1'b0;

        // Directed words: empty remap, the unused action, extreme levels,
        // table rebuilds after new counts, and a single-pixel histogram.
        add_word(ACT_REMAP, 8'd0,   1'b0);
        add_word(ACT_NONE,  8'd255, 1'b0);
        add_word(ACT_COUNT, 8'd0,   1'b0);
        add_word(ACT_COUNT, 8'd255, 1'b0);
        add_word(ACT_COUNT, 8'd255, 1'b0);
        add_word(ACT_COUNT, 8'd128, 1'b0);
        add_word(ACT_REMAP, 8'd0,   1'b0);
        add_word(ACT_REMAP, 8'd255, 1'b0);
        add_word(ACT_REMAP, 8'd128, 1'b0);
        add_word(ACT_REMAP, 8'd127, 1'b0);
        add_word(ACT_COUNT, 8'h55,  1'b0);
        add_word(ACT_COUNT, 8'hAA,  1'b0);
        add_word(ACT_REMAP, 8'hAA,  1'b0);
        add_word(ACT_REMAP, 8'h55,  1'b0);
        add_word(ACT_NONE,  8'd0,   1'b0);
        add_word(ACT_CLEAR, 8'd255, 1'b0);
        add_word(ACT_REMAP, 8'd64,  1'b0);
        add_word(ACT_COUNT, 8'd7,   1'b0);
        add_word(ACT_REMAP, 8'd6,   1'b0);
        add_word(ACT_REMAP, 8'd7,   1'b0);
        add_word(ACT_REMAP, 8'd255, 1'b0);
        add_word(ACT_CLEAR, 8'd0,   1'b1);

        // Mostly well-formed image passes with random content, some noise.
        while (words_sent < RANDOM_WORDS + 22) begin
            if ($urandom_range(0, 9) < 8) begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(lo, 255);
                if ($urandom_range(0, 3) == 0) begin
                    lo = 0;
                    hi = 255;
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) :
                                                  $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    add_word(ACT_CLEAR, PIX_W'($urandom_range(0, 255)),
                             $urandom_range(0, 9) == 0);
                repeat (n) add_word(ACT_COUNT, PIX_W'($urandom_range(lo, hi)), 1'b0);
                repeat ($urandom_range(1, 12))
                    add_word(ACT_REMAP, PIX_W'($urandom_range(0, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 8))
                    add_word(t_action'($urandom_range(0, 3)), PIX_W'($urandom_range(0, 255)),
                             1'b0);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != words_sent || results_due.size() != 0)
            @(negedge i_clk);

        // Closing words on a drained block: a reused table, a rebuild after
        // a new count, an empty remap after clear and a one-pixel histogram.
        add_word(ACT_COUNT, 8'd0,   1'b0);
        add_word(ACT_COUNT, 8'd255, 1'b0);
        add_word(ACT_REMAP, 8'd0,   1'b0);
        add_word(ACT_REMAP, 8'd200, 1'b0);
        add_word(ACT_REMAP, 8'd255, 1'b0);
        add_word(ACT_NONE,  8'd128, 1'b0);
        add_word(ACT_COUNT, 8'd1,   1'b0);
        add_word(ACT_REMAP, 8'd128, 1'b0);
        add_word(ACT_CLEAR, 8'd0,   1'b0);
        add_word(ACT_REMAP, 8'd255, 1'b0);
        add_word(ACT_COUNT, 8'd5,   1'b0);
        add_word(ACT_REMAP, 8'd4,   1'b0);
        add_word(ACT_REMAP, 8'd5,   1'b0);

        while (words_taken != words_sent || results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d predicted output words never arrived", results_due.size());
            err_count++;
        end
        $display("Checked %0d words: %0d counts (%0d refused at the limit), %0d remaps",
                 words_taken, n_counts, n_refused, n_remaps);
        $display("(%0d on an empty histogram) and %0d table builds, %0d mismatches.",
                 n_empty, n_builds, err_count);
        if (err_count == 0) begin
            $display("histogram_equalizer_8bit regression: pass");
        end else begin
            $display("histogram_equalizer_8bit regression: fail");
        end
        $finish;
    end

endmodule
